// ===== rtl/i2cbc_pkg.sv =====
package i2cbc_pkg;

    // widths fixed by the register map and the item layout
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int TIMER_BITS_D = 24;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_POLL_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_POLL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT        = 3'd4;

    // register reset values
    localparam logic [23:0] RST_SETTLE_TICKS       = 24'd2500000;
    localparam logic [9:0]  RST_HALF_PERIOD_TICKS  = 10'd10;
    localparam logic [23:0] RST_STRETCH_POLL_TICKS = 24'd100000;
    localparam logic [7:0]  RST_STRETCH_POLL_LIMIT = 8'd20;
    localparam logic [7:0]  RST_PULSE_LIMIT        = 8'd20;

    // outcome codes
    localparam logic [1:0] OUT_CLEARED     = 2'd0;
    localparam logic [1:0] OUT_SCL_LOW     = 2'd1;
    localparam logic [1:0] OUT_STRETCH_TMO = 2'd2;
    localparam logic [1:0] OUT_SDA_STUCK   = 2'd3;

    typedef struct packed {
        logic [23:0] settle_ticks;
        logic [9:0]  half_period_ticks;
        logic [23:0] stretch_poll_ticks;
        logic [7:0]  stretch_poll_limit;
        logic [7:0]  pulse_limit;
    } t_cfg;

    typedef struct packed {
        logic sda_level;
        logic scl_level;
        logic start_request;
    } t_tick;

    // packed so that scl_pull_low sits in bit 0
    typedef struct packed {
        logic [1:0] outcome;
        logic       finished;
        logic       busy_res;
        logic       sda_pullup_on;
        logic       scl_pullup_on;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } t_result;

endpackage

// ===== rtl/i2c_bus_clear_recovery_top.sv =====
// channel  | direction | handshake                      | payload
// ---------+-----------+--------------------------------+--------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready  | tick item: start, scl, sda
// m_axis   | out       | m_axis_tvalid / m_axis_tready  | drive state, busy, outcome; tlast
//          |           |                                | marks the item that ends a sequence
// cfg      | in        | i_cfg_we (no wait, write only) | index and data of one register
//
// one tick item is taken per clock while s_axis_tready is high; each item gives exactly one result item
// the sequencer steps on the accepting edge; its result is loaded at that same edge into the
// output register, or into the skid entry while the output register is stalled
// a skid entry behind the output register keeps the input open for one more item while stalled;
// the input drops ready only while both entries hold an item
// synchronous active-low reset: sequencer idle, counters zero, registers at defaults
module i2c_bus_clear_recovery_top #(
    parameter int TIMER_BITS = i2cbc_pkg::TIMER_BITS_D
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tick items in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] start_request, [1] scl_level, [2] sda_level, [7:3] zero
    input  logic [i2cbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result items out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] scl_pullup_on, [3] sda_pullup_on,
    // [4] busy_res, [6:5] outcome, [7] zero
    output logic [i2cbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // finished: high on the item that ends a sequence
    output logic                                 m_axis_tlast,
    // register writes
    input  logic                                 i_cfg_we,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [i2cbc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    i2cbc_pkg::t_cfg    cfg;
    i2cbc_pkg::t_tick   tick;
    i2cbc_pkg::t_result seq_result;
    i2cbc_pkg::t_result out_result;
    logic               step;

    // unused upper input bits are dropped here
    assign tick = s_axis_tdata[2:0];

    // sequencer advances only on an accepted item
    assign step = s_axis_tvalid && s_axis_tready;

    i2cbc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    i2cbc_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_tick   (tick),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    // output register with skid entry
    i2cbc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (seq_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_result)
    );

    // finished leaves on tlast, the other fields pack from bit 0 up
    assign m_axis_tdata = {1'b0, out_result.outcome, out_result.busy_res,
                           out_result.sda_pullup_on, out_result.scl_pullup_on,
                           out_result.sda_pull_low, out_result.scl_pull_low};
    assign m_axis_tlast = out_result.finished;

endmodule

// ===== rtl/i2cbc_cfg_regs.sv =====
module i2cbc_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [i2cbc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output i2cbc_pkg::t_cfg                      o_cfg
);

    i2cbc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks       <= i2cbc_pkg::RST_SETTLE_TICKS;
            r_cfg.half_period_ticks  <= i2cbc_pkg::RST_HALF_PERIOD_TICKS;
            r_cfg.stretch_poll_ticks <= i2cbc_pkg::RST_STRETCH_POLL_TICKS;
            r_cfg.stretch_poll_limit <= i2cbc_pkg::RST_STRETCH_POLL_LIMIT;
            r_cfg.pulse_limit        <= i2cbc_pkg::RST_PULSE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cbc_pkg::REG_SETTLE_TICKS:       r_cfg.settle_ticks <= i_cfg_wdata;
                i2cbc_pkg::REG_HALF_PERIOD_TICKS:  r_cfg.half_period_ticks <= i_cfg_wdata[9:0];
                i2cbc_pkg::REG_STRETCH_POLL_TICKS: r_cfg.stretch_poll_ticks <= i_cfg_wdata;
                i2cbc_pkg::REG_STRETCH_POLL_LIMIT: r_cfg.stretch_poll_limit <= i_cfg_wdata[7:0];
                i2cbc_pkg::REG_PULSE_LIMIT:        r_cfg.pulse_limit <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/i2cbc_seq.sv =====
module i2cbc_seq #(
    parameter int TIMER_BITS = i2cbc_pkg::TIMER_BITS_D
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cbc_pkg::t_tick   i_tick,
    input  i2cbc_pkg::t_cfg    i_cfg,
    output i2cbc_pkg::t_result o_result
);

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_SETTLE     = 7'b0000010,
        PH_PULSE_LOW  = 7'b0000100,
        PH_PULSE_HIGH = 7'b0001000,
        PH_STRETCH    = 7'b0010000,
        PH_START      = 7'b0100000,
        PH_STOP       = 7'b1000000
    } t_phase;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // loads clip at the largest count the timer holds
    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [23:0] v);
        logic [32:0] wide;
        wide = {9'd0, v};
        if (wide > TIMER_MAX) begin
            return TIMER_MAX[TIMER_BITS-1:0];
        end
        return wide[TIMER_BITS-1:0];
    endfunction

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [7:0]            r_pulses, n_pulses;
    logic [7:0]            r_polls, n_polls;
    logic [1:0]            r_last, n_last;

    logic       chk_sda;
    logic       fin;
    logic [1:0] fin_code;
    logic [7:0] polls_dec;

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_pulses = r_pulses;
        n_polls  = r_polls;
        n_last   = r_last;
        chk_sda  = 1'b0;
        fin      = 1'b0;
        fin_code = i2cbc_pkg::OUT_CLEARED;
        polls_dec = (r_polls != 8'd0) ? r_polls - 8'd1 : 8'd0;

        if (r_phase == PH_IDLE) begin
            if (i_tick.start_request) begin
                n_phase  = PH_SETTLE;
                n_timer  = sat_load(i_cfg.settle_ticks);
                n_pulses = i_cfg.pulse_limit;
                n_polls  = 8'd0;
            end
        end else if (r_timer != '0) begin
            n_timer = r_timer - {{(TIMER_BITS-1){1'b0}}, 1'b1};
        end else begin
            case (r_phase)
                PH_SETTLE: begin
                    if (!i_tick.scl_level) begin
                        fin      = 1'b1;
                        fin_code = i2cbc_pkg::OUT_SCL_LOW;
                    end else begin
                        chk_sda = 1'b1;
                    end
                end
                PH_PULSE_LOW: begin
                    n_phase = PH_PULSE_HIGH;
                    n_timer = sat_load({14'd0, i_cfg.half_period_ticks});
                end
                PH_PULSE_HIGH: begin
                    if (i_tick.scl_level) begin
                        chk_sda = 1'b1;
                    end else if (i_cfg.stretch_poll_limit == 8'd0) begin
                        fin      = 1'b1;
                        fin_code = i2cbc_pkg::OUT_STRETCH_TMO;
                    end else begin
                        n_polls = i_cfg.stretch_poll_limit;
                        n_phase = PH_STRETCH;
                        n_timer = sat_load(i_cfg.stretch_poll_ticks);
                    end
                end
                PH_STRETCH: begin
                    n_polls = polls_dec;
                    if (i_tick.scl_level) begin
                        chk_sda = 1'b1;
                    end else if (polls_dec == 8'd0) begin
                        fin      = 1'b1;
                        fin_code = i2cbc_pkg::OUT_STRETCH_TMO;
                    end else begin
                        n_timer = sat_load(i_cfg.stretch_poll_ticks);
                    end
                end
                PH_START: begin
                    n_phase = PH_STOP;
                    n_timer = sat_load({14'd0, i_cfg.half_period_ticks});
                end
                PH_STOP: begin
                    fin      = 1'b1;
                    fin_code = i2cbc_pkg::OUT_CLEARED;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            endcase
        end

        // next pulse, a stuck-data failure or the START, decided on SDA
        if (chk_sda) begin
            if (!i_tick.sda_level) begin
                if (r_pulses == 8'd0) begin
                    fin      = 1'b1;
                    fin_code = i2cbc_pkg::OUT_SDA_STUCK;
                end else begin
                    n_pulses = r_pulses - 8'd1;
                    n_phase  = PH_PULSE_LOW;
                    n_timer  = sat_load({14'd0, i_cfg.half_period_ticks});
                end
            end else begin
                n_phase = PH_START;
                n_timer = sat_load({14'd0, i_cfg.half_period_ticks});
            end
        end

        if (fin) begin
            n_phase = PH_IDLE;
            n_timer = '0;
            n_last  = fin_code;
        end
    end

    // drive state that holds after this tick
    always_comb begin
        o_result          = '0;
        o_result.finished = fin;
        o_result.outcome  = n_last;
        case (n_phase)
            PH_SETTLE, PH_PULSE_HIGH, PH_STRETCH, PH_STOP: begin
                o_result.scl_pullup_on = 1'b1;
                o_result.sda_pullup_on = 1'b1;
                o_result.busy_res      = 1'b1;
            end
            PH_PULSE_LOW: begin
                o_result.scl_pull_low  = 1'b1;
                o_result.sda_pullup_on = 1'b1;
                o_result.busy_res      = 1'b1;
            end
            PH_START: begin
                o_result.sda_pull_low  = 1'b1;
                o_result.scl_pullup_on = 1'b1;
                o_result.busy_res      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_pulses <= 8'd0;
            r_polls  <= 8'd0;
            r_last   <= i2cbc_pkg::OUT_CLEARED;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_pulses <= n_pulses;
            r_polls  <= n_polls;
            r_last   <= n_last;
        end
    end

endmodule

// ===== rtl/i2cbc_skid.sv =====
module i2cbc_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i2cbc_pkg::t_result i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output i2cbc_pkg::t_result o_data
);

    logic               r_main_valid;
    logic               r_skid_valid;
    i2cbc_pkg::t_result r_main;
    i2cbc_pkg::t_result r_skid;
    logic               in_acc;
    logic               main_free;

    assign o_ready   = !r_skid_valid;
    assign in_acc    = i_valid && !r_skid_valid;
    assign main_free = !r_main_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            r_main_valid <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (in_acc) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

// ===== tb/i2cbc_checker.sv =====
`timescale 1ns / 100ps

module i2cbc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // [0] start_request, [1] scl_level, [2] sda_level, [7:3] zero
    input  logic [i2cbc_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] scl_pullup_on, [3] sda_pullup_on,
    // [4] busy_res, [6:5] outcome, [7] zero
    input  logic [i2cbc_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  logic                                i_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [i2cbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [i2cbc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output int                                  o_mismatches,
    output int                                  o_outstanding,
    output logic                                o_seq_busy
);

    localparam int TB = i2cbc_pkg::TIMER_BITS_D;
    localparam longint unsigned TIMER_MAX = (64'd1 << TB) - 1;

    typedef enum logic [6:0] {
        SEQ_IDLE       = 7'b0000001,
        SEQ_SETTLE     = 7'b0000010,
        SEQ_PULSE_LOW  = 7'b0000100,
        SEQ_PULSE_HIGH = 7'b0001000,
        SEQ_STRETCH    = 7'b0010000,
        SEQ_START      = 7'b0100000,
        SEQ_STOP       = 7'b1000000
    } t_seq;

    i2cbc_pkg::t_cfg    cfg;
    t_seq               seq = SEQ_IDLE;
    logic [TB-1:0]      timer;
    logic [7:0]         pulses_left;
    logic [7:0]         polls_left;
    logic [1:0]         last_code;
    logic               seq_ended;
    int                 results_seen;
    i2cbc_pkg::t_result drive_q[$];

    assign o_seq_busy = (seq != SEQ_IDLE);

    // loads saturate at the widest value the timer holds
    function automatic logic [TB-1:0] timer_load(input logic [31:0] v);
        if (v > TIMER_MAX)
            return TIMER_MAX[TB-1:0];
        return v[TB-1:0];
    endfunction

    function automatic void end_seq(input logic [1:0] code);
        last_code = code;
        seq       = SEQ_IDLE;
        timer     = '0;
        seq_ended = 1'b1;
    endfunction

    // next pulse, stuck-low failure or the start condition, decided by sda
    function automatic void sda_decision(input logic sda_high);
        if (!sda_high) begin
            if (pulses_left == 0) begin
                end_seq(i2cbc_pkg::OUT_SDA_STUCK);
            end else begin
                pulses_left = pulses_left - 1'b1;
                seq         = SEQ_PULSE_LOW;
                timer       = timer_load(32'(cfg.half_period_ticks));
            end
        end else begin
            seq   = SEQ_START;
            timer = timer_load(32'(cfg.half_period_ticks));
        end
    endfunction

    function automatic i2cbc_pkg::t_result sequencer_tick(input i2cbc_pkg::t_tick tk);
        i2cbc_pkg::t_result r;
        seq_ended = 1'b0;
        if (seq == SEQ_IDLE) begin
            if (tk.start_request) begin
                seq         = SEQ_SETTLE;
                timer       = timer_load(32'(cfg.settle_ticks));
                pulses_left = cfg.pulse_limit;
                polls_left  = '0;
            end
        end else if (timer != 0) begin
            timer = timer - 1'b1;
        end else begin
            case (seq)
                SEQ_SETTLE: begin
                    if (!tk.scl_level)
                        end_seq(i2cbc_pkg::OUT_SCL_LOW);
                    else
                        sda_decision(tk.sda_level);
                end
                SEQ_PULSE_LOW: begin
                    seq   = SEQ_PULSE_HIGH;
                    timer = timer_load(32'(cfg.half_period_ticks));
                end
                SEQ_PULSE_HIGH: begin
                    if (tk.scl_level) begin
                        sda_decision(tk.sda_level);
                    end else if (cfg.stretch_poll_limit == 0) begin
                        end_seq(i2cbc_pkg::OUT_STRETCH_TMO);
                    end else begin
                        polls_left = cfg.stretch_poll_limit;
                        seq        = SEQ_STRETCH;
                        timer      = timer_load(32'(cfg.stretch_poll_ticks));
                    end
                end
                SEQ_STRETCH: begin
                    if (polls_left != 0)
                        polls_left = polls_left - 1'b1;
                    if (tk.scl_level)
                        sda_decision(tk.sda_level);
                    else if (polls_left == 0)
                        end_seq(i2cbc_pkg::OUT_STRETCH_TMO);
                    else
                        timer = timer_load(32'(cfg.stretch_poll_ticks));
                end
                SEQ_START: begin
                    seq   = SEQ_STOP;
                    timer = timer_load(32'(cfg.half_period_ticks));
                end
                SEQ_STOP: begin
                    end_seq(i2cbc_pkg::OUT_CLEARED);
                end
                default: begin
                    seq   = SEQ_IDLE;
                    timer = '0;
                end
            endcase
        end

        r = '0;
        case (seq)
            SEQ_SETTLE, SEQ_PULSE_HIGH, SEQ_STRETCH, SEQ_STOP: begin
                r.scl_pullup_on = 1'b1;
                r.sda_pullup_on = 1'b1;
                r.busy_res      = 1'b1;
            end
            SEQ_PULSE_LOW: begin
                r.scl_pull_low  = 1'b1;
                r.sda_pullup_on = 1'b1;
                r.busy_res      = 1'b1;
            end
            SEQ_START: begin
                r.sda_pull_low  = 1'b1;
                r.scl_pullup_on = 1'b1;
                r.busy_res      = 1'b1;
            end
            default: ;
        endcase
        r.finished = seq_ended;
        r.outcome  = last_code;
        return r;
    endfunction

    always @(posedge i_clk) begin
        i2cbc_pkg::t_result got;
        i2cbc_pkg::t_result want;
        logic               bad;
        if (!i_rst_n) begin
            cfg.settle_ticks       = i2cbc_pkg::RST_SETTLE_TICKS;
            cfg.half_period_ticks  = i2cbc_pkg::RST_HALF_PERIOD_TICKS;
            cfg.stretch_poll_ticks = i2cbc_pkg::RST_STRETCH_POLL_TICKS;
            cfg.stretch_poll_limit = i2cbc_pkg::RST_STRETCH_POLL_LIMIT;
            cfg.pulse_limit        = i2cbc_pkg::RST_PULSE_LIMIT;
            seq          = SEQ_IDLE;
            timer        = '0;
            pulses_left  = '0;
            polls_left   = '0;
            last_code    = '0;
            results_seen = 0;
            o_mismatches = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    i2cbc_pkg::REG_SETTLE_TICKS:
                        cfg.settle_ticks       = i_cfg_wdata[23:0];
                    i2cbc_pkg::REG_HALF_PERIOD_TICKS:
                        cfg.half_period_ticks  = i_cfg_wdata[9:0];
                    i2cbc_pkg::REG_STRETCH_POLL_TICKS:
                        cfg.stretch_poll_ticks = i_cfg_wdata[23:0];
                    i2cbc_pkg::REG_STRETCH_POLL_LIMIT:
                        cfg.stretch_poll_limit = i_cfg_wdata[7:0];
                    i2cbc_pkg::REG_PULSE_LIMIT:
                        cfg.pulse_limit        = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                drive_q.push_back(sequencer_tick(i2cbc_pkg::t_tick'(i_s_tdata[2:0])));
            if (i_m_tvalid === 1'b1 && i_m_tready) begin
                got               = '0;
                got.scl_pull_low  = i_m_tdata[0];
                got.sda_pull_low  = i_m_tdata[1];
                got.scl_pullup_on = i_m_tdata[2];
                got.sda_pullup_on = i_m_tdata[3];
                got.busy_res      = i_m_tdata[4];
                got.outcome       = i_m_tdata[6:5];
                got.finished      = i_m_tlast;
                results_seen++;
                if (drive_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("result %0d arrived with nothing pending: %h last %b",
                                 results_seen, i_m_tdata, i_m_tlast);
                end else begin
                    want = drive_q.pop_front();
                    bad  = (got.scl_pull_low  !== want.scl_pull_low)  ||
                           (got.sda_pull_low  !== want.sda_pull_low)  ||
                           (got.scl_pullup_on !== want.scl_pullup_on) ||
                           (got.sda_pullup_on !== want.sda_pullup_on) ||
                           (got.busy_res      !== want.busy_res)      ||
                           (got.finished      !== want.finished)      ||
                           (got.outcome       !== want.outcome);
                    if (bad) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("result %0d mismatch %s", results_seen,
                                     "(pull scl/sda, pullup scl/sda, busy, fin, code)");
                            $display("  expected %b%b %b%b %b %b %0d, got %b%b %b%b %b %b %0d",
                                     want.scl_pull_low, want.sda_pull_low,
                                     want.scl_pullup_on, want.sda_pullup_on,
                                     want.busy_res, want.finished, want.outcome,
                                     got.scl_pull_low, got.sda_pull_low,
                                     got.scl_pullup_on, got.sda_pullup_on,
                                     got.busy_res, got.finished, got.outcome);
                        end
                    end
                end
            end
        end
        o_outstanding = drive_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // tick item channel into the block
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [i2cbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;

    // result item channel out of the block
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [i2cbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              m_axis_tlast;

    // register write port
    logic                              cfg_we    = 1'b0;
    logic [i2cbc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [i2cbc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // checker outputs
    int   mismatches;
    int   pending;
    logic seq_busy;

    // pacing, in percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;

    i2c_bus_clear_recovery_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    i2cbc_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (pending),
        .o_seq_busy    (seq_busy)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // present one tick item and hold it until the block takes it
    task automatic send_tick(input logic start, input logic scl, input logic sda);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(i2cbc_pkg::IN_TDATA_W-3){1'b0}}, sda, scl, start};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        @(negedge clk);
    endtask

    // bring the sequencer back to idle with both lines high, then let the
    // result side empty out so registers can be rewritten safely
    task automatic quiesce();
        while (seq_busy)
            send_tick(1'b0, 1'b1, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // all five registers in index order, one write per cycle
    task automatic set_config(input logic [23:0] settle, input logic [9:0] half,
                              input logic [23:0] poll_ticks, input logic [7:0] poll_limit,
                              input logic [7:0] pulses);
        cfg_we    <= 1'b1;
        cfg_index <= i2cbc_pkg::REG_SETTLE_TICKS;
        cfg_wdata <= settle;
        @(negedge clk);
        cfg_index <= i2cbc_pkg::REG_HALF_PERIOD_TICKS;
        cfg_wdata <= 24'(half);
        @(negedge clk);
        cfg_index <= i2cbc_pkg::REG_STRETCH_POLL_TICKS;
        cfg_wdata <= poll_ticks;
        @(negedge clk);
        cfg_index <= i2cbc_pkg::REG_STRETCH_POLL_LIMIT;
        cfg_wdata <= 24'(poll_limit);
        @(negedge clk);
        cfg_index <= i2cbc_pkg::REG_PULSE_LIMIT;
        cfg_wdata <= 24'(pulses);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random ticks: each started sequence gets its own line profile so that
    // every ending (clean, scl held, stretch timeout, sda stuck) shows up
    task automatic run_phase(input int n_items, input int gap, input int stall,
                             input bit scl_free);
        int   scl_choices[4] = '{0, 4, 30, 85};
        int   sda_choices[4] = '{0, 30, 70, 100};
        int   scl_low_pct    = 0;
        int   sda_low_pct    = 0;
        logic start;
        logic scl;
        logic sda;
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n_items) begin
            if (!seq_busy) begin
                start = ($urandom_range(0, 2) == 0);
                if (start) begin
                    scl_low_pct = scl_choices[$urandom_range(0, 3)];
                    sda_low_pct = sda_choices[$urandom_range(0, 3)];
                end
            end else begin
                // starts while running must be ignored
                start = ($urandom_range(0, 9) == 0);
            end
            scl = scl_free ? ($urandom_range(0, 99) >= scl_low_pct) : 1'b1;
            sda = ($urandom_range(0, 99) >= sda_low_pct);
            send_tick(start, scl, sda);
        end
        quiesce();
    endtask

    // directed ticks, each entry is {sda, scl, start}
    localparam logic [2:0] DIRECTED [23] = '{
        3'b000, 3'b110,                     // idle, no start, lines both ways
        3'b111, 3'b000,                     // scl held low at first sample
        3'b001, 3'b010, 3'b011, 3'b010,     // one pulse, start ignored mid-run
        3'b000, 3'b100,                     // scl low after pulse, no polls allowed
        3'b111, 3'b010, 3'b010, 3'b010,     // sda stays low through the only pulse
        3'b010, 3'b010,
        3'b111, 3'b110, 3'b111, 3'b110,     // clean run: start, stop
        3'b110, 3'b111, 3'b110              // start on the ending tick is dropped
    };

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // a few idle ticks under the reset defaults
        repeat (4) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        quiesce();

        // directed part: no settle, one pulse allowed, no stretch polls
        set_config(24'd0, 10'd1, 24'd1, 8'd0, 8'd1);
        foreach (DIRECTED[k])
            send_tick(DIRECTED[k][0], DIRECTED[k][1], DIRECTED[k][2]);
        quiesce();

        // small random settings under each pacing mode
        set_config(24'($urandom_range(0, 6)), 10'($urandom_range(1, 3)),
                   24'($urandom_range(1, 3)), 8'($urandom_range(0, 4)),
                   8'($urandom_range(0, 6)));
        run_phase(330, 0, 0, 1'b1);
        set_config(24'($urandom_range(0, 6)), 10'($urandom_range(1, 3)),
                   24'($urandom_range(1, 3)), 8'($urandom_range(0, 4)),
                   8'($urandom_range(0, 6)));
        run_phase(330, 60, 0, 1'b1);
        set_config(24'($urandom_range(0, 6)), 10'($urandom_range(1, 3)),
                   24'($urandom_range(1, 3)), 8'($urandom_range(0, 4)),
                   8'($urandom_range(0, 6)));
        run_phase(330, 0, 60, 1'b1);
        set_config(24'($urandom_range(0, 6)), 10'($urandom_range(1, 3)),
                   24'($urandom_range(1, 3)), 8'($urandom_range(0, 4)),
                   8'($urandom_range(0, 6)));
        run_phase(330, 29, 29, 1'b1);

        // largest pulse and poll limits with the shortest waits
        set_config(24'd0, 10'd1, 24'd1, 8'd255, 8'd255);
        run_phase(200, 29, 29, 1'b1);

        // longer settle, half period and poll interval
        set_config(24'd40, 10'd12, 24'd5, 8'd6, 8'd3);
        run_phase(200, 0, 0, 1'b1);

        // longest settle time: written and held while idle, never started
        set_config(24'hFFFFFF, 10'd1, 24'd1, 8'd1, 8'd0);
        repeat (20) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        quiesce();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[i2c_bus_clear_recovery_top] OK");
        else
            $display("[i2c_bus_clear_recovery_top] ERROR");
        $finish;
    end

    // run limit, well above the slowest legal run
    initial begin
        #4000000;
        $display("[i2c_bus_clear_recovery_top] ERROR");
        $finish;
    end

endmodule
